// ===== rtl/filtered_nearest_neighbor_search_defines.svh =====
// assertion macros for the filtered nearest neighbor search
// needs clk and arst_n in the scope of each use
`ifndef FILTERED_NEAREST_NEIGHBOR_SEARCH_DEFINES_SVH
`define FILTERED_NEAREST_NEIGHBOR_SEARCH_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FNNS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define FNNS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fnns_pkg.sv =====
// shared types, codes and helpers for the filtered nearest neighbor search
// no dependencies
package fnns_pkg;

	typedef enum logic {
		FUNC_SUBJECT   = 1'b0,
		FUNC_CANDIDATE = 1'b1
	} func_t;

	typedef enum logic {
		KIND_PEDESTRIAN = 1'b0,
		KIND_OBSTACLE   = 1'b1
	} kind_t;

	localparam int unsigned CoordW = 16;
	localparam int unsigned ShoulderW = 12;
	localparam int unsigned IndexW = 10;
	localparam int unsigned DistW = 33;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] vx;
		logic signed [CoordW-1:0] vy;
		logic [ShoulderW-1:0]     half_width;
		logic [IndexW-1:0]        id;
	} subject_t;

	typedef struct packed {
		func_t                    func;
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic signed [CoordW-1:0] vel_x;
		logic signed [CoordW-1:0] vel_y;
		logic [ShoulderW-1:0]     shoulder;
		kind_t                    kind;
		logic [IndexW-1:0]        entity_index;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic             qualified;
		logic [DistW-1:0] dist_sq;
	} eval_t;

	// magnitude of a signed coordinate, one bit wider
	function automatic logic [CoordW:0] abs_coord(input logic signed [CoordW-1:0] v);
		logic signed [CoordW:0] ext;
		ext = {v[CoordW-1], v};
		return v[CoordW-1] ? (CoordW+1)'(-ext) : (CoordW+1)'(ext);
	endfunction

endpackage

// ===== rtl/fnns_if.sv =====
// valid/ready channels for the filtered nearest neighbor search
// depends on fnns_pkg
interface fnns_in_if import fnns_pkg::*; ();
	logic                     valid;
	logic                     ready;
	func_t                    func;
	logic signed [CoordW-1:0] pos_x;
	logic signed [CoordW-1:0] pos_y;
	logic signed [CoordW-1:0] vel_x;
	logic signed [CoordW-1:0] vel_y;
	logic [ShoulderW-1:0]     shoulder;
	kind_t                    kind;
	logic [IndexW-1:0]        entity_index;
	logic                     last;

	modport source (
		output valid, func, pos_x, pos_y, vel_x, vel_y, shoulder, kind, entity_index, last,
		input ready
	);
	modport sink (
		input valid, func, pos_x, pos_y, vel_x, vel_y, shoulder, kind, entity_index, last,
		output ready
	);
endinterface

interface fnns_out_if import fnns_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	kind_t            nearest_kind;
	logic [IndexW-1:0] nearest_index;
	logic [DistW-1:0] nearest_dist_sq;

	modport source (
		output valid, found, nearest_kind, nearest_index, nearest_dist_sq,
		input ready
	);
	modport sink (
		input valid, found, nearest_kind, nearest_index, nearest_dist_sq,
		output ready
	);
endinterface

// ===== rtl/filtered_nearest_neighbor_search.sv =====
// top level of the filtered nearest neighbor search
// depends on fnns_pkg, fnns_if, fnns_eval and filtered_nearest_neighbor_search_defines.svh
//
// one candidate beat per clock, sustained: a beat is registered at acceptance (_s1), the
// two 17x16 direction products, the two 17x17 squares for the distance and the cross-axis
// overlap run combinationally from it into a second register (_s2) as it moves on, and
// the running minimum plus the result register update as it leaves _s2; a result
// appears on the output channel once its last candidate has gone through _s1 and _s2
// into the result register. a subject beat loads the subject and clears the running
// search, and candidates after it are tested against it with no gap. the pipeline only
// holds when a result is ready to leave while the output register is still full and the
// sink is not ready. after reset the subject is all zero and no search is in progress
`include "filtered_nearest_neighbor_search_defines.svh"

module filtered_nearest_neighbor_search import fnns_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	fnns_in_if.sink       items,
	fnns_out_if.source    results
);

	// loaded subject
	subject_t          subject_q;

	// stage 1: registered input beat
	logic              valid_s1;
	item_t             item_s1;

	// stage 2: evaluated candidate
	logic              valid_s2;
	func_t             func_s2;
	kind_t             kind_s2;
	logic [IndexW-1:0] index_s2;
	logic              last_s2;
	eval_t             eval_s2;

	// running minimum
	logic              best_valid_q;
	kind_t             best_kind_q;
	logic [IndexW-1:0] best_id_q;
	logic [DistW-1:0]  best_dist_q;

	// result register
	logic              out_valid_q;
	logic              found_q;
	kind_t             nearest_kind_q;
	logic [IndexW-1:0] nearest_index_q;
	logic [DistW-1:0]  nearest_dist_q;

	eval_t             eval_c;
	item_t             item_in;
	logic              emit_s2, go_s2, free_s2, go_s1, free_s1, take;
	logic              nb_valid;
	kind_t             nb_kind;
	logic [IndexW-1:0] nb_id;
	logic [DistW-1:0]  nb_dist;

	assign item_in = '{
		func:         items.func,
		pos_x:        items.pos_x,
		pos_y:        items.pos_y,
		vel_x:        items.vel_x,
		vel_y:        items.vel_y,
		shoulder:     items.shoulder,
		kind:         items.kind,
		entity_index: items.entity_index,
		last:         items.last
	};

	// flow: each stage moves when the next one frees up
	assign emit_s2 = (func_s2 == FUNC_CANDIDATE) && last_s2;
	assign go_s2   = valid_s2 && (!emit_s2 || !out_valid_q || results.ready);
	assign free_s2 = !valid_s2 || go_s2;
	assign go_s1   = valid_s1 && free_s2;
	assign free_s1 = !valid_s1 || go_s1;
	assign items.ready = free_s1;

	fnns_eval u_eval (
		.subject (subject_q),
		.cand    (item_s1),
		.result  (eval_c)
	);

	// running minimum, ties keep the earlier candidate
	assign take = valid_s2 && (func_s2 == FUNC_CANDIDATE) && eval_s2.qualified
		&& (!best_valid_q || (eval_s2.dist_sq < best_dist_q));
	assign nb_valid = take ? 1'b1 : best_valid_q;
	assign nb_kind  = take ? kind_s2 : best_kind_q;
	assign nb_id    = take ? index_s2 : best_id_q;
	assign nb_dist  = take ? eval_s2.dist_sq : best_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (free_s1) begin
				valid_s1 <= items.valid;
			end
			if (free_s2) begin
				valid_s2 <= go_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && free_s1) begin
			item_s1 <= item_in;
		end
		if (go_s1) begin
			func_s2  <= item_s1.func;
			kind_s2  <= item_s1.kind;
			index_s2 <= item_s1.entity_index;
			last_s2  <= item_s1.last;
			eval_s2  <= eval_c;
		end
	end

	// subject is loaded as its beat leaves stage 1, ahead of the next candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subject_q <= '0;
		end else if (go_s1 && (item_s1.func == FUNC_SUBJECT)) begin
			subject_q <= '{
				x:          item_s1.pos_x,
				y:          item_s1.pos_y,
				vx:         item_s1.vel_x,
				vy:         item_s1.vel_y,
				half_width: item_s1.shoulder,
				id:         item_s1.entity_index
			};
		end
	end

	// search state clears on a subject beat and after each result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_valid_q <= 1'b0;
			best_kind_q  <= KIND_PEDESTRIAN;
			best_id_q    <= '0;
			best_dist_q  <= '0;
		end else if (go_s2) begin
			if ((func_s2 == FUNC_SUBJECT) || emit_s2) begin
				best_valid_q <= 1'b0;
				best_kind_q  <= KIND_PEDESTRIAN;
				best_id_q    <= '0;
				best_dist_q  <= '0;
			end else begin
				best_valid_q <= nb_valid;
				best_kind_q  <= nb_kind;
				best_id_q    <= nb_id;
				best_dist_q  <= nb_dist;
			end
		end
	end

	// result register, refilled in the same cycle it is drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s2 && emit_s2) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s2 && emit_s2) begin
			found_q         <= nb_valid;
			nearest_kind_q  <= nb_kind;
			nearest_index_q <= nb_id;
			nearest_dist_q  <= nb_dist;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.found           = found_q;
	assign results.nearest_kind    = nearest_kind_q;
	assign results.nearest_index   = nearest_index_q;
	assign results.nearest_dist_sq = nearest_dist_q;

	// an empty search reports all-zero fields
	`FNNS_ASSERT_NOW(a_empty_result_zero, out_valid_q && !found_q,
		(nearest_kind_q == KIND_PEDESTRIAN) && (nearest_index_q == '0) && (nearest_dist_q == '0),
		"result without a match carries nonzero fields")
	// no running minimum means cleared search fields
	`FNNS_ASSERT_NOW(a_idle_search_clear, !best_valid_q,
		(best_id_q == '0) && (best_dist_q == '0) && (best_kind_q == KIND_PEDESTRIAN),
		"search state not cleared while no match is held")
	// a subject beat leaving stage 2 restarts the search
	`FNNS_ASSERT_NEXT(a_subject_clears, go_s2 && (func_s2 == FUNC_SUBJECT), !best_valid_q,
		"search not cleared after subject load")
	// input backpressure only comes from a full pipeline behind a blocked result
	`FNNS_ASSERT_NOW(a_stall_cause, !items.ready,
		valid_s1 && valid_s2 && emit_s2 && out_valid_q && !results.ready,
		"input stalled without a blocked result")

endmodule

// ===== rtl/fnns_eval.sv =====
// candidate test: direction, self match and cross-axis overlap, plus squared distance
// depends on fnns_pkg
module fnns_eval import fnns_pkg::*; (
	input  subject_t subject,
	input  item_t    cand,
	output eval_t    result
);

	logic signed [CoordW:0]     dx, dy;
	logic signed [2*CoordW:0]   px, py;
	logic signed [2*CoordW+1:0] dot;
	logic signed [2*CoordW+1:0] sqx, sqy;
	logic [CoordW:0]            s_ax, s_ay, c_ax, c_ay;
	logic                       s_xmaj, s_ymaj, c_xmaj, c_ymaj;
	logic                       is_ped, self_hit, behind, overlap;
	logic [ShoulderW-1:0]       hs, hc;
	logic signed [CoordW-1:0]   sc, cc;
	logic signed [CoordW+1:0]   sc_e, cc_e, hs_e, hc_e;

	// offsets from candidate to subject
	assign dx = $signed({subject.x[CoordW-1], subject.x}) - $signed({cand.pos_x[CoordW-1], cand.pos_x});
	assign dy = $signed({subject.y[CoordW-1], subject.y}) - $signed({cand.pos_y[CoordW-1], cand.pos_y});

	assign px  = dx * subject.vx;
	assign py  = dy * subject.vy;
	assign dot = $signed({px[2*CoordW], px}) + $signed({py[2*CoordW], py});

	assign sqx = dx * dx;
	assign sqy = dy * dy;

	// main heading of subject and candidate
	assign s_ax   = abs_coord(subject.vx);
	assign s_ay   = abs_coord(subject.vy);
	assign c_ax   = abs_coord(cand.vel_x);
	assign c_ay   = abs_coord(cand.vel_y);
	assign s_xmaj = s_ax > s_ay;
	assign s_ymaj = s_ay > s_ax;
	assign c_xmaj = c_ax > c_ay;
	assign c_ymaj = c_ay > c_ax;

	assign is_ped   = (cand.kind == KIND_PEDESTRIAN);
	assign self_hit = is_ped && (cand.entity_index == subject.id);
	assign behind   = dot[2*CoordW+1];

	assign hs = is_ped ? subject.half_width : '0;
	assign hc = (is_ped && ((s_xmaj && c_xmaj) || (s_ymaj && c_ymaj))) ? cand.shoulder : '0;
	assign sc = s_xmaj ? subject.y : subject.x;
	assign cc = s_xmaj ? cand.pos_y : cand.pos_x;

	assign sc_e = $signed({{2{sc[CoordW-1]}}, sc});
	assign cc_e = $signed({{2{cc[CoordW-1]}}, cc});
	assign hs_e = $signed({6'b0, hs});
	assign hc_e = $signed({6'b0, hc});

	// intervals meet when each low end sits at or below the other high end
	assign overlap = ((sc_e - hs_e) <= (cc_e + hc_e)) && ((cc_e - hc_e) <= (sc_e + hs_e));

	assign result.qualified = !self_hit && behind && overlap;
	assign result.dist_sq   = sqx[DistW-1:0] + sqy[DistW-1:0];

endmodule

// ===== dv/tb.sv =====
// testbench for the filtered nearest neighbor search: directed and random searches
// depends on rtl/fnns_pkg.sv, rtl/fnns_if.sv and the block itself, compiled before this file
module tb;
	import fnns_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// one search result as it should leave the block
	typedef struct {
		logic              found;
		kind_t             kind;
		logic [IndexW-1:0] idx;
		logic [DistW-1:0]  dist_sq;
	} nearest_t;

	logic clk;
	logic arst_n;

	fnns_in_if  items_ch ();
	fnns_out_if results_ch ();

	filtered_nearest_neighbor_search uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch)
	);

	// subject and running best, as the block should hold them
	subject_t          subj;
	logic              best_valid;
	kind_t             best_kind;
	logic [IndexW-1:0] best_index;
	longint            best_dist;

	// results still owed by the block, oldest first
	nearest_t pending_nearest[$];
	nearest_t want;

	int  err_count;
	int  sent_count;
	// set for the back-to-back stretch: no source gaps, sink always ready
	bit  steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#2_000_000;
		$display("tb: done, errors");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		$display("tb: mismatch at %0t ns: %s", $time, msg);
	endtask

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// coordinate within +/- span of base, wrapping at the field width
	function automatic logic [CoordW-1:0] near_coord(input logic signed [CoordW-1:0] base,
			input int span);
		int offset;
		offset = int'($urandom_range(2 * span)) - span;
		return CoordW'(int'(base) + offset);
	endfunction

	// update the expected state for one accepted beat; a last candidate owes a result
	task automatic track_search(input item_t it);
		longint   px, py, vx, vy, sx, sy, svx, svy;
		longint   dx, dy, dot, hs, hc, s_c, c_c, lo, hi, d;
		bit       s_xmaj, s_ymaj, ok;
		nearest_t res;
		if (it.func == FUNC_SUBJECT) begin
			// new subject clears the search; last is ignored here
			subj.x = it.pos_x;
			subj.y = it.pos_y;
			subj.vx = it.vel_x;
			subj.vy = it.vel_y;
			subj.half_width = it.shoulder;
			subj.id = it.entity_index;
			best_valid = 1'b0;
			best_kind = KIND_PEDESTRIAN;
			best_index = '0;
			best_dist = 0;
		end else begin
			px = $signed(it.pos_x);
			py = $signed(it.pos_y);
			vx = $signed(it.vel_x);
			vy = $signed(it.vel_y);
			sx = $signed(subj.x);
			sy = $signed(subj.y);
			svx = $signed(subj.vx);
			svy = $signed(subj.vy);
			dx = sx - px;
			dy = sy - py;
			// candidate must lie along the subject heading: dot product strictly negative
			dot = dx * svx + dy * svy;
			s_xmaj = magnitude(svx) > magnitude(svy);
			s_ymaj = magnitude(svy) > magnitude(svx);
			hs = 0;
			hc = 0;
			ok = 1'b1;
			if (it.kind == KIND_PEDESTRIAN) begin
				// only a pedestrian can be the subject itself
				if (it.entity_index == subj.id)
					ok = 1'b0;
				hs = subj.half_width;
				// candidate shoulder counts only when both share a strict main heading
				if ((s_xmaj && magnitude(vx) > magnitude(vy)) ||
						(s_ymaj && magnitude(vy) > magnitude(vx)))
					hc = it.shoulder;
			end
			if (dot >= 0)
				ok = 1'b0;
			// overlap on the axis across the subject heading
			s_c = s_xmaj ? sy : sx;
			c_c = s_xmaj ? py : px;
			lo = (s_c - hs) > (c_c - hc) ? (s_c - hs) : (c_c - hc);
			hi = (s_c + hs) < (c_c + hc) ? (s_c + hs) : (c_c + hc);
			if (lo > hi)
				ok = 1'b0;
			if (ok) begin
				d = dx * dx + dy * dy;
				// strict compare keeps the earlier candidate on a tie
				if (!best_valid || d < best_dist) begin
					best_valid = 1'b1;
					best_kind = it.kind;
					best_index = it.entity_index;
					best_dist = d;
				end
			end
			if (it.last) begin
				res.found = best_valid;
				res.kind = best_valid ? best_kind : KIND_PEDESTRIAN;
				res.idx = best_valid ? best_index : '0;
				res.dist_sq = best_valid ? DistW'(best_dist) : '0;
				pending_nearest = {pending_nearest, res};
				best_valid = 1'b0;
				best_kind = KIND_PEDESTRIAN;
				best_index = '0;
				best_dist = 0;
			end
		end
	endtask

	// present one beat at the falling edge, optionally after idle cycles, and hold it
	// until the block takes it
	task automatic offer_item(input item_t it);
		while (!steady && $urandom_range(99) < 38) begin
			@(negedge clk);
			items_ch.valid <= 1'b0;
		end
		@(negedge clk);
		items_ch.valid <= 1'b1;
		items_ch.func <= it.func;
		items_ch.pos_x <= it.pos_x;
		items_ch.pos_y <= it.pos_y;
		items_ch.vel_x <= it.vel_x;
		items_ch.vel_y <= it.vel_y;
		items_ch.shoulder <= it.shoulder;
		items_ch.kind <= it.kind;
		items_ch.entity_index <= it.entity_index;
		items_ch.last <= it.last;
		do @(posedge clk); while (!items_ch.ready);
		track_search(it);
		sent_count++;
	endtask

	function automatic item_t build_item(input func_t f, input int x, input int y,
			input int vx, input int vy, input int sh, input kind_t k, input int idx,
			input bit last_beat);
		item_t it;
		it.func = f;
		it.pos_x = CoordW'(x);
		it.pos_y = CoordW'(y);
		it.vel_x = CoordW'(vx);
		it.vel_y = CoordW'(vy);
		it.shoulder = ShoulderW'(sh);
		it.kind = k;
		it.entity_index = IndexW'(idx);
		it.last = last_beat;
		return it;
	endfunction

	function automatic item_t random_subject();
		item_t it;
		int    v;
		it = '0;
		it.func = FUNC_SUBJECT;
		if ($urandom_range(3) == 0) begin
			it.pos_x = CoordW'($urandom);
			it.pos_y = CoordW'($urandom);
		end else begin
			it.pos_x = near_coord('0, 8192);
			it.pos_y = near_coord('0, 8192);
		end
		case ($urandom_range(9))
			0: begin
				// standing subject: nothing can qualify
				it.vel_x = '0;
				it.vel_y = '0;
			end
			1: begin
				// no strict main heading
				v = $urandom_range(1, 2000);
				it.vel_x = CoordW'($urandom_range(1) ? v : -v);
				it.vel_y = CoordW'($urandom_range(1) ? v : -v);
			end
			2, 3: begin
				it.vel_x = CoordW'($urandom);
				it.vel_y = CoordW'($urandom);
			end
			default: begin
				it.vel_x = near_coord('0, 600);
				it.vel_y = near_coord('0, 600);
			end
		endcase
		it.shoulder = $urandom_range(1) ? ShoulderW'($urandom) : ShoulderW'($urandom_range(400));
		it.kind = kind_t'($urandom_range(1));
		it.entity_index = IndexW'($urandom);
		it.last = ($urandom_range(7) == 0);
		return it;
	endfunction

	function automatic item_t random_candidate(input bit last_beat);
		item_t it;
		int    span;
		it = '0;
		it.func = FUNC_CANDIDATE;
		it.kind = kind_t'($urandom_range(1));
		if ($urandom_range(4) == 0) begin
			it.pos_x = CoordW'($urandom);
			it.pos_y = CoordW'($urandom);
		end else begin
			span = $urandom_range(1) ? 96 : 1536;
			it.pos_x = near_coord(subj.x, span);
			it.pos_y = near_coord(subj.y, span);
		end
		// obstacles have no width, so often put them right on the subject's line
		if (it.kind == KIND_OBSTACLE && $urandom_range(1)) begin
			if (magnitude(subj.vx) > magnitude(subj.vy))
				it.pos_y = subj.y;
			else
				it.pos_x = subj.x;
		end
		case ($urandom_range(3))
			0: begin
				it.vel_x = '0;
				it.vel_y = '0;
			end
			1: begin
				it.vel_x = CoordW'($urandom);
				it.vel_y = CoordW'($urandom);
			end
			default: begin
				it.vel_x = near_coord('0, 512);
				it.vel_y = near_coord('0, 512);
			end
		endcase
		it.shoulder = $urandom_range(1) ? ShoulderW'($urandom) : ShoulderW'($urandom_range(64));
		it.entity_index = ($urandom_range(3) == 0) ? subj.id : IndexW'($urandom);
		it.last = last_beat;
		return it;
	endfunction

	// candidates right after reset meet the all-zero subject: zero velocity, no hits
	task automatic test_unloaded_subject();
		offer_item(build_item(FUNC_CANDIDATE, 256, 0, 0, 0, 100, KIND_PEDESTRIAN, 3, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, 0, 0, 0, 0, 0, KIND_OBSTACLE, 0, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, -256, 512, 0, 0, 0, KIND_PEDESTRIAN, 0, 1'b1));
	endtask

	// last set on a subject beat gives nothing; the search closes on the candidate
	task automatic test_subject_last();
		offer_item(build_item(FUNC_SUBJECT, 0, 0, 256, 0, 64, KIND_PEDESTRIAN, 9, 1'b1));
		offer_item(build_item(FUNC_CANDIDATE, 512, 0, 0, 0, 0, KIND_OBSTACLE, 2, 1'b1));
	endtask

	// pedestrian with the subject's index is skipped, obstacle with it is not
	task automatic test_self_match();
		offer_item(build_item(FUNC_SUBJECT, -1000, 200, 0, -300, 128, KIND_PEDESTRIAN, 5, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, -1000, 0, 0, -50, 20, KIND_PEDESTRIAN, 5, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, -1000, -100, 0, 0, 0, KIND_OBSTACLE, 5, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, -950, -500, 0, -50, 20, KIND_PEDESTRIAN, 6, 1'b1));
	endtask

	// standing subject: dot product is zero, nothing qualifies even on top of it
	task automatic test_zero_velocity();
		offer_item(build_item(FUNC_SUBJECT, 300, 300, 0, 0, 4095, KIND_OBSTACLE, 1, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, 300, 600, 0, 100, 200, KIND_PEDESTRIAN, 2, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, 300, 0, 0, 0, 0, KIND_OBSTACLE, 3, 1'b1));
	endtask

	// equal distances keep the first; shoulder counts only with a shared strict heading
	task automatic test_tie_and_heading();
		offer_item(build_item(FUNC_SUBJECT, 0, 0, 0, 256, 200, KIND_PEDESTRIAN, 0, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, 100, 300, 0, 100, 50, KIND_PEDESTRIAN, 7, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, -100, 300, 0, -100, 50, KIND_PEDESTRIAN, 8, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, 250, 200, 100, 0, 60, KIND_PEDESTRIAN, 9, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, 240, 100, 50, 50, 60, KIND_PEDESTRIAN, 10, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, 0, 900, 0, 0, 0, KIND_OBSTACLE, 11, 1'b1));
	endtask

	// full-scale coordinates, velocities, shoulders and indices
	task automatic test_extremes();
		offer_item(build_item(FUNC_SUBJECT, -32768, -32768, 32767, 32767, 4095,
			KIND_PEDESTRIAN, 1023, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, 32767, -32768, 0, 0, 0, KIND_OBSTACLE, 0, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, -32768, 32767, 0, 0, 0, KIND_OBSTACLE, 1023, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, -28673, 32767, -32768, -32768, 4095,
			KIND_PEDESTRIAN, 1022, 1'b1));
		offer_item(build_item(FUNC_SUBJECT, 32767, 32767, -32768, 0, 0, KIND_OBSTACLE, 0, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, -32768, 28672, -32768, 1, 4095,
			KIND_PEDESTRIAN, 1023, 1'b0));
		offer_item(build_item(FUNC_CANDIDATE, -32768, 32767, 0, 32767, 4095,
			KIND_PEDESTRIAN, 512, 1'b1));
	endtask

	// mostly whole searches with random content; some reuse the loaded subject and some
	// are abandoned without a last candidate
	task automatic test_random_searches(input int target);
		item_t cand;
		item_t prev;
		int    n;
		int    variant;
		while (sent_count < target) begin
			variant = $urandom_range(99);
			if (variant < 80)
				offer_item(random_subject());
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++) begin
				cand = random_candidate((variant < 92) && (i == n - 1));
				// same spot as the one before makes an exact distance tie
				if (i > 0 && $urandom_range(7) == 0) begin
					cand.pos_x = prev.pos_x;
					cand.pos_y = prev.pos_y;
				end
				offer_item(cand);
				prev = cand;
			end
		end
	endtask

	// long stretch with both sides at full rate
	task automatic test_back_to_back(input int beats);
		steady = 1'b1;
		test_random_searches(sent_count + beats);
		steady = 1'b0;
	endtask

	// result sink: random back-pressure except in the steady stretch
	always @(negedge clk)
		results_ch.ready <= steady || ($urandom_range(99) >= 38);

	// result checker, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (pending_nearest.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = pending_nearest.pop_front();
				if (results_ch.found !== want.found)
					report_mismatch($sformatf("found %0b, expected %0b",
						results_ch.found, want.found));
				if (results_ch.nearest_kind !== want.kind)
					report_mismatch($sformatf("nearest_kind %0b, expected %0b",
						results_ch.nearest_kind, want.kind));
				if (results_ch.nearest_index !== want.idx)
					report_mismatch($sformatf("nearest_index %0d, expected %0d",
						results_ch.nearest_index, want.idx));
				if (results_ch.nearest_dist_sq !== want.dist_sq)
					report_mismatch($sformatf("nearest_dist_sq %0d, expected %0d",
						results_ch.nearest_dist_sq, want.dist_sq));
			end
		end
	end

	initial begin
		int waited;
		err_count = 0;
		sent_count = 0;
		steady = 1'b0;
		subj = '0;
		best_valid = 1'b0;
		best_kind = KIND_PEDESTRIAN;
		best_index = '0;
		best_dist = 0;
		arst_n = 1'b0;
		items_ch.valid = 1'b0;
		items_ch.func = FUNC_SUBJECT;
		items_ch.pos_x = '0;
		items_ch.pos_y = '0;
		items_ch.vel_x = '0;
		items_ch.vel_y = '0;
		items_ch.shoulder = '0;
		items_ch.kind = KIND_PEDESTRIAN;
		items_ch.entity_index = '0;
		items_ch.last = 1'b0;
		results_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_unloaded_subject();
		test_subject_last();
		test_self_match();
		test_zero_velocity();
		test_tie_and_heading();
		test_extremes();
		test_random_searches(350);
		test_back_to_back(150);
		test_random_searches(650);

		@(negedge clk);
		items_ch.valid <= 1'b0;
		// let the pipeline empty, then keep watching for any stray beat
		waited = 0;
		while (pending_nearest.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pending_nearest.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_nearest.size()));
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

// ===== filtered_nearest_neighbor_search.f =====
+incdir+rtl
rtl/fnns_pkg.sv
rtl/fnns_if.sv
rtl/fnns_eval.sv
rtl/filtered_nearest_neighbor_search.sv
dv/tb.sv
